// ===== src/fibonacci_tile_layout_top_defines.svh =====
// Assertion macros used by the tile layout top module.
`ifndef FIBONACCI_TILE_LAYOUT_TOP_DEFINES_SVH
`define FIBONACCI_TILE_LAYOUT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FTL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("ftl check failed");
`define FTL_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("ftl reset check failed");
`else
`define FTL_ASSERT(lbl, prop)
`define FTL_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== src/ftl_pkg.sv =====
// Types, codes and constants of the tile layout block.
package ftl_pkg;

  typedef logic signed [17:0] coord_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_AREA_X          = 3'd0,
    REG_AREA_Y          = 3'd1,
    REG_AREA_WIDTH      = 3'd2,
    REG_AREA_HEIGHT     = 3'd3,
    REG_MASTER_FRACTION = 3'd4,
    REG_DWINDLE_MODE    = 3'd5
  } reg_idx_t;

  // Turn phase: window index modulo four
  localparam logic [1:0] PHASE_TOP    = 2'd0;
  localparam logic [1:0] PHASE_RIGHT  = 2'd1;
  localparam logic [1:0] PHASE_BOTTOM = 2'd2;
  localparam logic [1:0] PHASE_LEFT   = 2'd3;

  // Place of a window among the first ones
  localparam logic [1:0] EARLY_FIRST  = 2'd0;
  localparam logic [1:0] EARLY_SECOND = 2'd1;
  localparam logic [1:0] EARLY_LATER  = 2'd2;

  localparam int FracBits = 10;

  localparam logic signed [15:0] AREA_X_RST = 16'sd0;
  localparam logic signed [15:0] AREA_Y_RST = 16'sd0;
  localparam logic [14:0] AREA_WIDTH_RST  = 15'd1920;
  localparam logic [14:0] AREA_HEIGHT_RST = 15'd1080;
  localparam logic [10:0] MASTER_FRACTION_RST = 11'd563;
  localparam logic [15:0] MASTER_WIDTH_RST = 16'((1920 * 563) >> FracBits);

  typedef struct packed {
    logic signed [15:0] area_x;
    logic signed [15:0] area_y;
    logic [14:0]        area_width;
    logic [14:0]        area_height;
    logic [15:0]        master_width;
    logic               dwindle_mode;
  } cfg_t;

  typedef struct packed {
    coord_t     x;
    coord_t     y;
    coord_t     w;
    coord_t     h;
    logic [1:0] phase;
    logic [1:0] early;
  } cell_t;

endpackage

// ===== src/fibonacci_tile_layout_top.sv =====
// An accepted window is held in the input stage register, then loaded into the result register.
// Throughput: one window per cycle while the result side is ready; the running cell is
// updated from the input register through one combinational halving, add and subtract path.
// Reset: clears both pipeline valids and the running cell, and loads the
// configuration registers with their defaults. No clearing pass.
`include "fibonacci_tile_layout_top_defines.svh"
module fibonacci_tile_layout_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          border_width,
  input  logic                first_window,
  input  logic                last_window,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [17:0]  win_x,
  output logic signed [17:0]  win_y,
  output logic signed [17:0]  win_width,
  output logic signed [17:0]  win_height,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  ftl_pkg::cfg_t   cfg;
  ftl_pkg::cell_t  tile, tile_next;
  ftl_pkg::coord_t width_next, height_next;

  logic       s1_valid, s1_first, s1_last, s1_adv;
  logic [7:0] s1_border;

  assign cfg_ready = 1'b1;

  ftl_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ftl_step u_step (
    .cfg          (cfg),
    .cur          (tile),
    .border_width (s1_border),
    .first_window (s1_first),
    .last_window  (s1_last),
    .nxt          (tile_next),
    .out_width    (width_next),
    .out_height   (height_next)
  );

  // advance when the result register is free or being drained
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_border <= border_width;
      s1_first  <= first_window;
      s1_last   <= last_window;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      tile      <= '0;
    end else begin
      if (s1_adv) begin
        out_valid <= 1'b1;
        tile      <= tile_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_x      <= tile_next.x;
      win_y      <= tile_next.y;
      win_width  <= width_next;
      win_height <= height_next;
    end
  end

  `FTL_ASSERT(a_out_from_stage, $rose(out_valid) |-> $past(s1_valid))
  `FTL_ASSERT(a_first_restarts, (s1_adv && s1_first) |=>
    (tile.phase == ftl_pkg::PHASE_RIGHT && tile.early == ftl_pkg::EARLY_SECOND))
  `FTL_ASSERT(a_early_phase, (tile.early == ftl_pkg::EARLY_FIRST) |-> (tile.phase == ftl_pkg::PHASE_TOP))
  `FTL_ASSERT(a_no_overrun, (s1_valid && !s1_adv) |-> !in_ready)
  `FTL_ASSERT_RST(a_reset_clears, rst |=> (!s1_valid && !out_valid))

endmodule

// ===== src/ftl_cfg.sv =====
// Configuration register file with the registered master width product.
module ftl_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [15:0]        wr_data,
  output ftl_pkg::cfg_t      cfg
);

  logic [10:0] master_fraction;
  logic [25:0] product;

  assign product = 26'(cfg.area_width) * 26'(master_fraction);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.area_x       <= ftl_pkg::AREA_X_RST;
      cfg.area_y       <= ftl_pkg::AREA_Y_RST;
      cfg.area_width   <= ftl_pkg::AREA_WIDTH_RST;
      cfg.area_height  <= ftl_pkg::AREA_HEIGHT_RST;
      cfg.dwindle_mode <= 1'b0;
      cfg.master_width <= ftl_pkg::MASTER_WIDTH_RST;
      master_fraction  <= ftl_pkg::MASTER_FRACTION_RST;
    end else begin
      // master width follows the product of the registers in the next cycle
      cfg.master_width <= product[25:ftl_pkg::FracBits];
      if (wr_en) begin
        case (ftl_pkg::reg_idx_t'(wr_index))
          ftl_pkg::REG_AREA_X:          cfg.area_x       <= wr_data;
          ftl_pkg::REG_AREA_Y:          cfg.area_y       <= wr_data;
          ftl_pkg::REG_AREA_WIDTH:      cfg.area_width   <= wr_data[14:0];
          ftl_pkg::REG_AREA_HEIGHT:     cfg.area_height  <= wr_data[14:0];
          ftl_pkg::REG_MASTER_FRACTION: master_fraction  <= wr_data[10:0];
          ftl_pkg::REG_DWINDLE_MODE:    cfg.dwindle_mode <= wr_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== src/ftl_step.sv =====
// Next cell and result sizes for one window from the running cell.
module ftl_step (
  input  ftl_pkg::cfg_t     cfg,
  input  ftl_pkg::cell_t    cur,
  input  logic [7:0]        border_width,
  input  logic              first_window,
  input  logic              last_window,
  output ftl_pkg::cell_t    nxt,
  output ftl_pkg::coord_t   out_width,
  output ftl_pkg::coord_t   out_height
);

  ftl_pkg::coord_t x0, y0, w0, h0, x1, y1, w1, h1, x2, y2, w3, y3;
  ftl_pkg::coord_t half_src, half, two_bw, area_y_ext;
  logic [1:0] ph, early;
  logic       odd, split, dw;

  always_comb begin
    dw         = cfg.dwindle_mode;
    area_y_ext = {{2{cfg.area_y[15]}}, cfg.area_y};
    two_bw     = {9'd0, border_width, 1'b0};

    // restart from the work area
    if (first_window) begin
      x0    = {{2{cfg.area_x[15]}}, cfg.area_x};
      y0    = area_y_ext;
      w0    = {3'd0, cfg.area_width};
      h0    = {3'd0, cfg.area_height};
      ph    = ftl_pkg::PHASE_TOP;
      early = ftl_pkg::EARLY_FIRST;
    end else begin
      x0    = cur.x;
      y0    = cur.y;
      w0    = cur.w;
      h0    = cur.h;
      ph    = cur.phase;
      early = cur.early;
    end

    odd      = ph[0];
    half_src = odd ? h0 : w0;
    // halve toward zero
    half     = (half_src + $signed({17'd0, half_src[17]})) >>> 1;
    split    = (half > two_bw) && !last_window;

    w1 = (split && !odd) ? half : w0;
    h1 = (split && odd) ? half : h0;
    x1 = x0;
    y1 = y0;
    if (split && !dw) begin
      if (ph == ftl_pkg::PHASE_BOTTOM) x1 = x0 + w1;
      if (ph == ftl_pkg::PHASE_LEFT)   y1 = y0 + h1;
    end

    x2 = x1;
    y2 = y1;
    case (ph)
      ftl_pkg::PHASE_TOP:    y2 = dw ? (y1 + h1) : (y1 - h1);
      ftl_pkg::PHASE_RIGHT:  x2 = x1 + w1;
      ftl_pkg::PHASE_BOTTOM: y2 = y1 + h1;
      ftl_pkg::PHASE_LEFT:   x2 = dw ? (x1 + w1) : (x1 - w1);
      default: ;
    endcase

    w3 = w1;
    y3 = y2;
    if (early == ftl_pkg::EARLY_FIRST) begin
      if (!last_window) w3 = {2'd0, cfg.master_width};
      y3 = area_y_ext;
    end else if (early == ftl_pkg::EARLY_SECOND) begin
      w3 = {3'd0, cfg.area_width} - w1;
    end

    nxt.x     = x2;
    nxt.y     = y3;
    nxt.w     = w3;
    nxt.h     = h1;
    nxt.phase = ph + 2'd1;
    nxt.early = (early == ftl_pkg::EARLY_LATER) ? ftl_pkg::EARLY_LATER : early + 2'd1;

    out_width  = w3 - two_bw;
    out_height = h1 - two_bw;
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the Fibonacci tile layout block: directed and random layouts against a predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 300000;
  localparam int REPORT_MAX = 10;
  // Indexes outside the register map; writes to them must change nothing
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    ftl_pkg::coord_t x;
    ftl_pkg::coord_t y;
    ftl_pkg::coord_t w;
    ftl_pkg::coord_t h;
  } rect_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [7:0] border_width;
  logic first_window;
  logic last_window;
  logic out_valid;
  logic out_ready;
  ftl_pkg::coord_t win_x;
  ftl_pkg::coord_t win_y;
  ftl_pkg::coord_t win_width;
  ftl_pkg::coord_t win_height;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  // Predicted configuration
  logic signed [15:0] set_area_x = ftl_pkg::AREA_X_RST;
  logic signed [15:0] set_area_y = ftl_pkg::AREA_Y_RST;
  logic [14:0] set_area_w = ftl_pkg::AREA_WIDTH_RST;
  logic [14:0] set_area_h = ftl_pkg::AREA_HEIGHT_RST;
  logic [10:0] set_fraction = ftl_pkg::MASTER_FRACTION_RST;
  logic set_dwindle = 1'b0;

  // Predicted running cell
  ftl_pkg::coord_t tile_x = '0;
  ftl_pkg::coord_t tile_y = '0;
  ftl_pkg::coord_t tile_w = '0;
  ftl_pkg::coord_t tile_h = '0;
  logic [1:0] tile_phase = ftl_pkg::PHASE_TOP;
  logic [1:0] tile_rank = ftl_pkg::EARLY_FIRST;

  rect_t pending_rects[$];
  rect_t want_rect;
  int mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  int rx_hold = 0;

  fibonacci_tile_layout_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .border_width(border_width),
    .first_window(first_window),
    .last_window(last_window),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .win_x(win_x),
    .win_y(win_y),
    .win_width(win_width),
    .win_height(win_height),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic int to_coord(input int v);
    ftl_pkg::coord_t t;
    t = 18'(v);
    return int'(t);
  endfunction

  function automatic void note_reg(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      ftl_pkg::REG_AREA_X:          set_area_x = data;
      ftl_pkg::REG_AREA_Y:          set_area_y = data;
      ftl_pkg::REG_AREA_WIDTH:      set_area_w = data[14:0];
      ftl_pkg::REG_AREA_HEIGHT:     set_area_h = data[14:0];
      ftl_pkg::REG_MASTER_FRACTION: set_fraction = data[10:0];
      ftl_pkg::REG_DWINDLE_MODE:    set_dwindle = data[0];
      default: ;
    endcase
  endfunction

  // Advance the running cell by one window and return its rectangle
  function automatic rect_t place_window(input logic [7:0] bw, input logic first,
                                         input logic last);
    int x, y, w, h, half, border;
    logic [1:0] ph;
    rect_t r;
    border = int'(bw);
    if (first) begin
      tile_x = {{2{set_area_x[15]}}, set_area_x};
      tile_y = {{2{set_area_y[15]}}, set_area_y};
      tile_w = {3'b000, set_area_w};
      tile_h = {3'b000, set_area_h};
      tile_phase = ftl_pkg::PHASE_TOP;
      tile_rank = ftl_pkg::EARLY_FIRST;
    end
    x = int'(tile_x);
    y = int'(tile_y);
    w = int'(tile_w);
    h = int'(tile_h);
    ph = tile_phase;
    half = ph[0] ? h / 2 : w / 2;
    if (half > 2 * border && !last) begin
      if (ph[0]) h = half;
      else w = half;
      if (ph == ftl_pkg::PHASE_BOTTOM && !set_dwindle) x = to_coord(x + w);
      else if (ph == ftl_pkg::PHASE_LEFT && !set_dwindle) y = to_coord(y + h);
    end
    case (ph)
      ftl_pkg::PHASE_TOP:    y = to_coord(set_dwindle ? y + h : y - h);
      ftl_pkg::PHASE_RIGHT:  x = to_coord(x + w);
      ftl_pkg::PHASE_BOTTOM: y = to_coord(y + h);
      default:               x = to_coord(set_dwindle ? x + w : x - w);
    endcase
    if (tile_rank == ftl_pkg::EARLY_FIRST) begin
      if (!last) w = to_coord((int'(set_area_w) * int'(set_fraction)) >> ftl_pkg::FracBits);
      y = int'(set_area_y);
    end else if (tile_rank == ftl_pkg::EARLY_SECOND) begin
      w = to_coord(int'(set_area_w) - w);
    end
    tile_x = 18'(x);
    tile_y = 18'(y);
    tile_w = 18'(w);
    tile_h = 18'(h);
    r.x = tile_x;
    r.y = tile_y;
    r.w = 18'(int'(tile_w) - 2 * border);
    r.h = 18'(int'(tile_h) - 2 * border);
    tile_phase = ph + 2'd1;
    if (tile_rank == ftl_pkg::EARLY_FIRST) tile_rank = ftl_pkg::EARLY_SECOND;
    else tile_rank = ftl_pkg::EARLY_LATER;
    return r;
  endfunction

  function automatic logic [7:0] pick_border();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one window; keep valid high after the transfer so back-to-back items need no drop
  task automatic send_window(input logic [7:0] bw, input logic first, input logic last);
    int gap;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    border_width <= bw;
    first_window <= first;
    last_window <= last;
    do @(posedge clk); while (!in_ready);
    pending_rects.push_back(place_window(bw, first, last));
  endtask

  task automatic send_layout(input int count);
    for (int i = 0; i < count; i++) send_window(pick_border(), i == 0, i == count - 1);
  endtask

  // Drop valid and let every result drain before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_rects.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    note_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic randomize_area();
    logic [15:0] d;
    case ($urandom_range(0, 3))
      0: d = 16'h8000;
      1: d = 16'h7FFF;
      default: d = 16'($urandom_range(0, 65535));
    endcase
    cfg_write(ftl_pkg::REG_AREA_X, d);
    case ($urandom_range(0, 3))
      0: d = 16'h8000;
      1: d = 16'h7FFF;
      default: d = 16'($urandom_range(0, 65535));
    endcase
    cfg_write(ftl_pkg::REG_AREA_Y, d);
    case ($urandom_range(0, 5))
      0: d = 16'd32767;
      1: d = 16'd1;
      2: d = 16'($urandom_range(0, 65535));
      default: d = 16'($urandom_range(64, 4000));
    endcase
    cfg_write(ftl_pkg::REG_AREA_WIDTH, d);
    case ($urandom_range(0, 5))
      0: d = 16'd32767;
      1: d = 16'd1;
      2: d = 16'($urandom_range(0, 65535));
      default: d = 16'($urandom_range(64, 4000));
    endcase
    cfg_write(ftl_pkg::REG_AREA_HEIGHT, d);
    case ($urandom_range(0, 6))
      0: d = 16'd1024;
      1: d = 16'd0;
      2: d = 16'd2047;
      3: d = 16'($urandom_range(0, 65535));
      default: d = 16'($urandom_range(0, 1024));
    endcase
    cfg_write(ftl_pkg::REG_MASTER_FRACTION, d);
    cfg_write(ftl_pkg::REG_DWINDLE_MODE, 16'($urandom_range(0, 65535)));
  endtask

  // Compare each transfer on the result side with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_rects.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result x=%0d y=%0d w=%0d h=%0d",
                   win_x, win_y, win_width, win_height);
      end else begin
        want_rect = pending_rects.pop_front();
        if (win_x !== want_rect.x || win_y !== want_rect.y ||
            win_width !== want_rect.w || win_height !== want_rect.h) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("mismatch: expected x=%0d y=%0d w=%0d h=%0d, got x=%0d y=%0d w=%0d h=%0d",
                     want_rect.x, want_rect.y, want_rect.w, want_rect.h,
                     win_x, win_y, win_width, win_height);
        end
      end
    end
  end

  // Result side: random stall bursts, plus a long hold-off on request
  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Windows straight out of reset, then a plain layout on the default area
  task automatic test_reset_sequence();
    send_window(8'd0, 1'b0, 1'b0);
    send_window(8'd1, 1'b0, 1'b0);
    send_window(8'd0, 1'b0, 1'b1);
    for (int i = 0; i < 5; i++) send_window(8'd2, i == 0, i == 4);
    wait_idle();
  endtask

  task automatic test_extremes();
    cfg_write(ftl_pkg::REG_AREA_X, 16'h8000);
    cfg_write(ftl_pkg::REG_AREA_Y, 16'h7FFF);
    cfg_write(ftl_pkg::REG_AREA_WIDTH, 16'd32767);
    cfg_write(ftl_pkg::REG_AREA_HEIGHT, 16'd32767);
    cfg_write(ftl_pkg::REG_MASTER_FRACTION, 16'd1024);
    cfg_write(ftl_pkg::REG_DWINDLE_MODE, 16'd0);
    for (int i = 0; i < 6; i++) send_window(8'd0, i == 0, i == 5);
    // only window keeps the full width
    send_window(8'hFF, 1'b1, 1'b1);
    wait_idle();
    cfg_write(ftl_pkg::REG_MASTER_FRACTION, 16'd2047);
    cfg_write(ftl_pkg::REG_DWINDLE_MODE, 16'd1);
    for (int i = 0; i < 4; i++) send_window(i[0] ? 8'h00 : 8'hFF, i == 0, i == 3);
    // carry on past the last window without a new first flag
    send_window(8'd3, 1'b0, 1'b0);
    send_window(8'd0, 1'b0, 1'b0);
    wait_idle();
    // tiny area: every split is refused
    cfg_write(ftl_pkg::REG_AREA_WIDTH, 16'd1);
    cfg_write(ftl_pkg::REG_AREA_HEIGHT, 16'd1);
    cfg_write(ftl_pkg::REG_MASTER_FRACTION, 16'd0);
    cfg_write(ftl_pkg::REG_DWINDLE_MODE, 16'd0);
    for (int i = 0; i < 3; i++) send_window(8'd0, i == 0, i == 2);
    wait_idle();
    cfg_write(REG_SPARE_LO, 16'hFFFF);
    cfg_write(REG_SPARE_HI, 16'hFFFF);
    send_window(8'd1, 1'b1, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_layouts();
    int sent;
    int len;
    for (int p = 0; p < 12; p++) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      randomize_area();
      sent = 0;
      while (sent < 65) begin
        if ($urandom_range(0, 7) == 0) begin
          send_window(pick_border(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          sent++;
        end else begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
          send_layout(len);
          sent += len;
        end
      end
      wait_idle();
    end
  endtask

  // Hold the result side while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 80;
    repeat (3) send_layout(10);
    wait_idle();
  endtask

  task automatic test_full_rate();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    randomize_area();
    repeat (12) send_layout($urandom_range(4, 12));
    wait_idle();
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    border_width <= '0;
    first_window <= 1'b0;
    last_window <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_sequence();
    test_extremes();
    test_random_layouts();
    test_backpressure();
    test_full_rate();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
